/* hw/rtl/rsc_pkg.sv */
// Package for the radix string converter: beat types, controller/datapath
// command and status structs, ASCII constants and the digit helper functions.
// Depends on nothing; every other file of the block but rsc_ram imports it.
package rsc_pkg;

	localparam int CHAR_W     = 8;
	localparam int OUT_CHAR_W = 7;
	localparam int RADIX_W    = 6;
	localparam int DIGIT_W    = 6;

	// Quotient bits retired per cycle by the radix divider.
	localparam int DIV_BITS_PER_CYC = 4;

	localparam logic [CHAR_W-1:0] ASC_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] ASC_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] ASC_LA   = 8'h61;
	localparam logic [CHAR_W-1:0] ASC_LZ   = 8'h7a;
	localparam logic [CHAR_W-1:0] ASC_UA   = 8'h41;
	localparam logic [CHAR_W-1:0] ASC_UZ   = 8'h5a;

	localparam logic [DIGIT_W-1:0] DEC_TEN   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// Configuration register indexes (word address bit 2).
	localparam logic REG_IN_BASE  = 1'b0;
	localparam logic REG_OUT_BASE = 1'b1;

	localparam logic [RADIX_W-1:0] IN_BASE_RST  = 6'd10;
	localparam logic [RADIX_W-1:0] OUT_BASE_RST = 6'd16;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              in_last;
	} in_beat_t;

	typedef struct packed {
		logic [OUT_CHAR_W-1:0] out_char;
		logic                  out_last;
		logic                  out_error;
		logic                  out_overflow;
	} out_beat_t;

	typedef struct packed {
		logic               ok;
		logic [DIGIT_W-1:0] digit;
	} dec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accum;
		logic start;
		logic div_step;
		logic digit_done;
		logic emit_ld;
		logic err_ld;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic error_seen;
		logic div_last;
		logic conv_done;
		logic idx_zero;
		logic out_free;
	} sts_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic dec_t decode_char(input logic [CHAR_W-1:0] c);
		dec_t         res;
		logic [CHAR_W-1:0] t;
		res = '0;
		t   = '0;
		if (c >= ASC_ZERO && c <= ASC_NINE) begin
			t         = c - ASC_ZERO;
			res.ok    = 1'b1;
			res.digit = t[DIGIT_W-1:0];
		end else if (c >= ASC_LA && c <= ASC_LZ) begin
			t         = c - ASC_LA + {2'b00, DEC_TEN};
			res.ok    = 1'b1;
			res.digit = t[DIGIT_W-1:0];
		end else if (c >= ASC_UA && c <= ASC_UZ) begin
			t         = c - ASC_UA + {2'b00, DEC_TEN};
			res.ok    = 1'b1;
			res.digit = t[DIGIT_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [OUT_CHAR_W-1:0] encode_digit(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] s;
		if (d < DEC_TEN) begin
			s = ASC_ZERO + {2'b00, d};
		end else begin
			s = ASC_LA + {2'b00, d} - {2'b00, DEC_TEN};
		end
		return s[OUT_CHAR_W-1:0];
	endfunction

endpackage

/* hw/rtl/radix_string_converter.sv */
// Flow: while the controller is idle, characters that are not last are taken
// one per cycle. A last character moves it to S_FIN; unless an error was seen,
// each output digit then comes from the 4-bit-per-cycle radix divider (S_DIV,
// then S_DIGIT); the digit store is then read back (S_EMIT_RD, S_EMIT_WR).
// Reset (arst_n low) clears the number state and the controller; the radix
// registers return to 10 and 16. The digit store needs no clearing.
module radix_string_converter import rsc_pkg::*; #(
	parameter int VALUE_BITS     = 64,
	parameter int MAX_OUT_DIGITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Source characters.
	input  logic        src_valid,
	output logic        src_stall,
	input  in_beat_t    src_beat,
	// Destination digits.
	output logic        dst_valid,
	input  logic        dst_stall,
	output out_beat_t   dst_beat
);

	logic [RADIX_W-1:0] in_base_q;
	logic [RADIX_W-1:0] out_base_q;
	logic               cfg_wr;
	cmd_t               cmd;
	sts_t               sts;

	// The register is picked by word address bit 2; the byte offset bits are
	// ignored, as is usual for a word-wide register file.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= IN_BASE_RST;
			out_base_q <= OUT_BASE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IN_BASE) begin
				in_base_q <= pwdata[RADIX_W-1:0];
			end else begin
				out_base_q <= pwdata[RADIX_W-1:0];
			end
		end
	end

	// Raw register values are read back; clamping to 2..36 happens at use.
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_OUT_BASE) begin
			prdata[RADIX_W-1:0] = out_base_q;
		end else begin
			prdata[RADIX_W-1:0] = in_base_q;
		end
	end

	// The controller sequences accumulate, divide, store and emit; the
	// datapath owns every register that carries a number or a digit.
	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_last (src_beat.in_last),
		.sts      (sts),
		.src_stall(src_stall),
		.cmd      (cmd)
	);

	rsc_dpath #(
		.VALUE_BITS    (VALUE_BITS),
		.MAX_OUT_DIGITS(MAX_OUT_DIGITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_base  (in_base_q),
		.out_base (out_base_q),
		.in_char  (src_beat.in_char),
		.cmd      (cmd),
		.dst_stall(dst_stall),
		.sts      (sts),
		.dst_valid(dst_valid),
		.dst_beat (dst_beat)
	);

endmodule

/* hw/rtl/rsc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rsc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/rsc_ctrl.sv */
// Controller state machine of the radix string converter.
// Depends on rsc_pkg for the command and status structs.
module rsc_ctrl import rsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	input  logic src_last,
	input  sts_t sts,
	output logic src_stall,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_DIV,
		S_DIGIT,
		S_EMIT_RD,
		S_EMIT_WR,
		S_ERR
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (src_valid && src_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= sts.error_seen ? S_ERR : S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					state_q <= sts.conv_done ? S_EMIT_RD : S_DIV;
				end
				S_EMIT_RD: begin
					if (sts.out_free) begin
						state_q <= S_EMIT_WR;
					end
				end
				S_EMIT_WR: begin
					state_q <= sts.idx_zero ? S_IDLE : S_EMIT_RD;
				end
				S_ERR: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.accum      = (state_q == S_IDLE) && src_valid;
		cmd.start      = (state_q == S_FIN) && !sts.error_seen;
		cmd.div_step   = (state_q == S_DIV);
		cmd.digit_done = (state_q == S_DIGIT);
		cmd.emit_ld    = (state_q == S_EMIT_WR);
		cmd.err_ld     = (state_q == S_ERR) && sts.out_free;
	end

	assign src_stall = (state_q != S_IDLE);

endmodule

/* hw/rtl/rsc_dpath.sv */
// Datapath of the radix string converter: multiply-add accumulator, radix
// divider, digit store and output register. Depends on rsc_pkg and rsc_ram.
module rsc_dpath import rsc_pkg::*; #(
	parameter int VALUE_BITS     = 64,
	parameter int MAX_OUT_DIGITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RADIX_W-1:0] in_base,
	input  logic [RADIX_W-1:0] out_base,
	input  logic [CHAR_W-1:0]  in_char,
	input  cmd_t               cmd,
	input  logic               dst_stall,
	output sts_t               sts,
	output logic               dst_valid,
	output out_beat_t          dst_beat
);

	localparam int MAC_W  = VALUE_BITS + RADIX_W;
	localparam int STEPS  = (VALUE_BITS + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
	localparam int DIV_W  = STEPS * DIV_BITS_PER_CYC;
	localparam int STEP_W = $clog2(STEPS);
	localparam int ADDR_W = $clog2(MAX_OUT_DIGITS);

	logic [VALUE_BITS-1:0] acc_q;
	logic                  err_q;
	logic                  ovf_q;
	logic                  run_ovf_q;
	logic [DIV_W-1:0]      quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [STEP_W-1:0]     step_q;
	logic [ADDR_W-1:0]     n_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  out_valid_q;
	out_beat_t             out_beat_q;

	logic [RADIX_W-1:0] sr;
	logic [RADIX_W-1:0] dr;
	dec_t               dec;
	logic [MAC_W-1:0]   mac;
	logic               digit_ok;
	logic [DIV_W-1:0]   quo_nxt;
	logic [DIGIT_W-1:0] rem_nxt;
	logic [DIGIT_W-1:0] rd_digit;
	logic               out_free;

	assign sr       = clamp_radix(in_base);
	assign dr       = clamp_radix(out_base);
	assign dec      = decode_char(in_char);
	assign digit_ok = dec.ok && (dec.digit < sr);
	assign mac      = MAC_W'(acc_q) * MAC_W'(sr) + MAC_W'(dec.digit);

	// Restoring division by the destination radix; the quotient shifts in
	// behind the dividend bits as they leave the top of the register.
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		logic [DIV_W-1:0]   q;
		r = rem_q;
		q = quo_q;
		t = '0;
		for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
			t = {r, q[DIV_W-1]};
			q = {q[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dr}) begin
				t    = t - {1'b0, dr};
				q[0] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		quo_nxt = q;
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			err_q  <= 1'b0;
			ovf_q  <= 1'b0;
			step_q <= '0;
			n_q    <= '0;
		end else begin
			if (cmd.accum) begin
				if (digit_ok) begin
					acc_q <= mac[VALUE_BITS-1:0];
					if (|mac[MAC_W-1:VALUE_BITS]) begin
						ovf_q <= 1'b1;
					end
				end else begin
					err_q <= 1'b1;
				end
			end
			if (cmd.start || cmd.err_ld) begin
				acc_q <= '0;
				err_q <= 1'b0;
				ovf_q <= 1'b0;
			end
			if (cmd.start) begin
				step_q <= '0;
				n_q    <= '0;
			end
			if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.digit_done) begin
				step_q <= '0;
				n_q    <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q     <= DIV_W'(acc_q);
			rem_q     <= '0;
			run_ovf_q <= ovf_q;
		end
		if (cmd.div_step) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
		if (cmd.digit_done) begin
			rem_q <= '0;
			idx_q <= n_q;
		end
		if (cmd.emit_ld) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	rsc_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_OUT_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (cmd.digit_done),
		.waddr(n_q),
		.wdata(rem_q),
		.raddr(idx_q),
		.rdata(rd_digit)
	);

	assign out_free = !out_valid_q || !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld || cmd.err_ld) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_beat_q.out_char     <= encode_digit(rd_digit);
			out_beat_q.out_last     <= (idx_q == '0);
			out_beat_q.out_error    <= 1'b0;
			out_beat_q.out_overflow <= run_ovf_q;
		end else if (cmd.err_ld) begin
			out_beat_q.out_char     <= '0;
			out_beat_q.out_last     <= 1'b1;
			out_beat_q.out_error    <= 1'b1;
			out_beat_q.out_overflow <= ovf_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.error_seen = err_q;
		sts.div_last   = (step_q == STEP_W'(STEPS - 1));
		sts.conv_done  = (quo_q == '0) || (n_q == ADDR_W'(MAX_OUT_DIGITS - 1));
		sts.idx_zero   = (idx_q == '0);
		sts.out_free   = out_free;
	end

	assign dst_valid = out_valid_q;
	assign dst_beat  = out_beat_q;

endmodule

/* hw/rtl/rsc_checker.sv */
// Port-level assertions for the radix string converter, bound to the top level.
// Depends on rsc_pkg for the beat type and ASCII constants.
module rsc_checker import rsc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      src_stall,
	input logic      dst_valid,
	input logic      dst_stall,
	input out_beat_t dst_beat
);

	// A stalled result beat stays put.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_beat))
		else $error("stalled result beat changed");

	// An error result is a single beat that carries no character.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_beat.out_error |-> dst_beat.out_last && dst_beat.out_char == '0)
		else $error("malformed error beat");

	// Every digit beat is a lower-case digit character.
	a_digit_char: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_beat.out_error |->
			({1'b0, dst_beat.out_char} >= ASC_ZERO && {1'b0, dst_beat.out_char} <= ASC_NINE) ||
			({1'b0, dst_beat.out_char} >= ASC_LA && {1'b0, dst_beat.out_char} <= ASC_LZ))
		else $error("digit beat is not a digit character");

	// No new character is taken while a digit run is still being emitted.
	a_run_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_beat.out_last |-> src_stall)
		else $error("input taken in the middle of a digit run");

endmodule

bind radix_string_converter rsc_checker u_chk (.*);
